// File: rtl/core/chr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chr_pkg
// Shared types and constants of the consistent-hash ring.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int unsigned MaxNodes      = 16;
  localparam int unsigned PointsPerNode = 3;
  localparam int unsigned NodeBits      = 16;

  localparam logic [63:0] MixMulA = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } chr_op_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_EMPTY   = 3'd1,
    STAT_PRESENT = 3'd2,
    STAT_ABSENT  = 3'd3,
    STAT_COLLIDE = 3'd4,
    STAT_FULL    = 3'd5
  } chr_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_GO,
    ST_MIX_WAIT,
    ST_FIND,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } chr_state_e;

  typedef struct packed {
    logic node_we;
    logic point_we;
    logic set_used;
    logic clr_used;
  } chr_wr_t;

endpackage
`default_nettype wire

// File: rtl/core/chr_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chr_mix
// Iterative splitmix64 finalizer: one 32x32 multiplier, three passes per
// 64-bit product, two products per mix.
// ----------------------------------------------------------------------------
module chr_mix (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] value_i,
  output logic             done_o,
  output logic [63:0]      result_o
);

  logic [63:0] v_q, v_d, acc_q, acc_d;
  logic [1:0]  step_q, step_d;
  logic        rnd_q, rnd_d;
  logic        run_q, run_d;
  logic        done_q, done_d;

  logic [63:0] konst;
  logic [31:0] opa, opb;
  logic [63:0] prod;
  logic [63:0] tsum;

  always_comb begin
    konst = rnd_q ? chr_pkg::MixMulB : chr_pkg::MixMulA;
    unique case (step_q)
      2'd0: begin
        opa = v_q[31:0];
        opb = konst[31:0];
      end
      2'd1: begin
        opa = v_q[31:0];
        opb = konst[63:32];
      end
      default: begin
        opa = v_q[63:32];
        opb = konst[31:0];
      end
    endcase
    prod = 64'(opa) * 64'(opb);
    tsum = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
  end

  always_comb begin
    v_d    = v_q;
    acc_d  = acc_q;
    step_d = step_q;
    rnd_d  = rnd_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = value_i ^ (value_i >> 30);
      step_d = 2'd0;
      rnd_d  = 1'b0;
      run_d  = 1'b1;
    end else if (run_q) begin
      unique case (step_q)
        2'd0: begin
          acc_d  = prod;
          step_d = 2'd1;
        end
        2'd1: begin
          acc_d  = tsum;
          step_d = 2'd2;
        end
        default: begin
          step_d = 2'd0;
          if (rnd_q) begin
            v_d    = tsum ^ (tsum >> 31);
            run_d  = 1'b0;
            done_d = 1'b1;
          end else begin
            v_d   = tsum ^ (tsum >> 27);
            rnd_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      rnd_q  <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      rnd_q  <= rnd_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    acc_q <= acc_d;
  end

  assign done_o   = done_q;
  assign result_o = v_q;

endmodule
`default_nettype wire

// File: rtl/core/chr_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chr_store
// Ring storage: slot valid flags, node id memory and ring point memory,
// each memory with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module chr_store #(
  parameter  int unsigned MAX_NODES       = chr_pkg::MaxNodes,
  parameter  int unsigned POINTS_PER_NODE = chr_pkg::PointsPerNode,
  localparam int unsigned TotalPts        = MAX_NODES * POINTS_PER_NODE,
  localparam int unsigned SlotW           = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int unsigned PtW             = (TotalPts > 1) ? $clog2(TotalPts) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire chr_pkg::chr_wr_t     wr_i,
  input  wire logic [SlotW-1:0]     wr_slot_i,
  input  wire logic [PtW-1:0]       wr_pt_i,
  input  wire logic [15:0]          wr_node_i,
  input  wire logic [63:0]          wr_point_i,
  input  wire logic [SlotW-1:0]     rd_slot_i,
  input  wire logic [PtW-1:0]       rd_pt_i,
  output logic [MAX_NODES-1:0]      used_o,
  output logic [15:0]               rd_node_o,
  output logic [63:0]               rd_point_o
);

  logic [MAX_NODES-1:0] used_q;
  logic [15:0]          node_mem [MAX_NODES];
  logic [63:0]          point_mem [TotalPts];
  logic [15:0]          rd_node_q;
  logic [63:0]          rd_point_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_i.set_used) begin
      used_q[wr_slot_i] <= 1'b1;
    end else if (wr_i.clr_used) begin
      used_q[wr_slot_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.node_we) begin
      node_mem[wr_slot_i] <= wr_node_i;
    end
    rd_node_q <= node_mem[rd_slot_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.point_we) begin
      point_mem[wr_pt_i] <= wr_point_i;
    end
    rd_point_q <= point_mem[rd_pt_i];
  end

  assign used_o     = used_q;
  assign rd_node_o  = rd_node_q;
  assign rd_point_o = rd_point_q;

endmodule
`default_nettype wire

// File: rtl/core/consistent_hash_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// consistent_hash_ring
// Consistent-hash ring with splitmix64 points: lookup, insert and remove.
// ----------------------------------------------------------------------------
// One beat in, one beat out; the block takes one item at a time and holds
// in_stall_o high until that item's result is loaded into the output
// register. Every mix runs on a single 32x32 multiplier, and every search
// reads its memory one entry per cycle: node ids in the slot search, ring
// points in the point scan.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module consistent_hash_ring #(
  parameter int unsigned MAX_NODES       = chr_pkg::MaxNodes,
  parameter int unsigned POINTS_PER_NODE = chr_pkg::PointsPerNode,
  parameter int unsigned NODE_BITS       = chr_pkg::NodeBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [63:0] lookup_key_i,
  input  wire logic [15:0] node_ident_i,
  input  wire logic [63:0] seed_first_i,
  input  wire logic [63:0] seed_second_i,
  input  wire logic [63:0] seed_third_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      owner_node_o,
  output logic [63:0]      mixed_point_o
);

  localparam int unsigned TotalPts = MAX_NODES * POINTS_PER_NODE;
  localparam int unsigned SlotW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned PtW      = (TotalPts > 1) ? $clog2(TotalPts) : 1;
  localparam int unsigned KW       = (POINTS_PER_NODE > 1) ? $clog2(POINTS_PER_NODE) : 1;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(MAX_NODES - 1);
  localparam logic [PtW-1:0]   LastPt   = PtW'(TotalPts - 1);
  localparam logic [KW-1:0]    LastK    = KW'(POINTS_PER_NODE - 1);
  localparam logic [15:0]      IdMask   = (NODE_BITS >= 16) ? 16'hFFFF :
                                          16'((32'd1 << NODE_BITS) - 32'd1);

  chr_pkg::chr_state_e state_q, state_d;
  chr_pkg::chr_op_e    op_q, op_d;

  logic [63:0]      key_q, key_d;
  logic [15:0]      id_q, id_d;
  logic [63:0]      seed_q [POINTS_PER_NODE];
  logic [63:0]      seed_d [POINTS_PER_NODE];
  logic [63:0]      np_q [POINTS_PER_NODE];
  logic [63:0]      np_d [POINTS_PER_NODE];
  logic [63:0]      m_q, m_d;
  logic [KW-1:0]    k_q, k_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [PtW-1:0]   pa_q, pa_d;
  logic             scan_on_q, scan_on_d;
  logic             tag_vld_q, tag_vld_d;
  logic             tag_used_q, tag_used_d;
  logic [SlotW-1:0] tag_slot_q, tag_slot_d;
  logic             hit_q, hit_d;
  logic [SlotW-1:0] hit_slot_q, hit_slot_d;
  logic             free_found_q, free_found_d;
  logic [SlotW-1:0] free_slot_q, free_slot_d;
  logic             collide_q, collide_d;
  logic             any_q, any_d;
  logic [63:0]      best_low_q, best_low_d;
  logic [15:0]      own_low_q, own_low_d;
  logic             above_q, above_d;
  logic [63:0]      best_up_q, best_up_d;
  logic [15:0]      own_up_q, own_up_d;
  logic             out_valid_q, out_valid_d;
  logic [2:0]       status_out_q;
  logic [15:0]      owner_out_q;
  logic [63:0]      mixed_out_q;

  logic        in_acc;
  logic        out_load;
  logic        scan_done;
  logic [63:0] seeds_in [3];

  logic                 mix_start;
  logic [63:0]          mix_value;
  logic                 mix_done;
  logic [63:0]          mix_res;
  chr_pkg::chr_wr_t     wr;
  logic [SlotW-1:0]     wr_slot;
  logic [PtW-1:0]       wr_pt;
  logic [MAX_NODES-1:0] used;
  logic [15:0]          rd_node;
  logic [63:0]          rd_point;

  chr_pkg::chr_status_e res_status;
  logic [15:0]          res_owner;
  logic [63:0]          res_mixed;

  assign seeds_in[0] = seed_first_i;
  assign seeds_in[1] = seed_second_i;
  assign seeds_in[2] = seed_third_i;

  assign in_acc    = in_valid_i && (state_q == chr_pkg::ST_IDLE);
  assign out_load  = (state_q == chr_pkg::ST_RESULT) && (!out_valid_q || !out_stall_i);
  assign scan_done = !scan_on_q && !tag_vld_q;

  chr_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mix_start),
    .value_i  (mix_value),
    .done_o   (mix_done),
    .result_o (mix_res)
  );

  chr_store #(
    .MAX_NODES       (MAX_NODES),
    .POINTS_PER_NODE (POINTS_PER_NODE)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .wr_slot_i  (wr_slot),
    .wr_pt_i    (wr_pt),
    .wr_node_i  (id_q),
    .wr_point_i (np_q[k_q]),
    .rd_slot_i  (slot_q),
    .rd_pt_i    (pa_q),
    .used_o     (used),
    .rd_node_o  (rd_node),
    .rd_point_o (rd_point)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chr_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (chr_pkg::chr_op_e'(operation_i))
            chr_pkg::OP_LOOKUP: state_d = chr_pkg::ST_MIX_GO;
            chr_pkg::OP_INSERT: state_d = chr_pkg::ST_FIND;
            chr_pkg::OP_REMOVE: state_d = chr_pkg::ST_FIND;
            default:            state_d = chr_pkg::ST_RESULT;
          endcase
        end
      end
      chr_pkg::ST_MIX_GO: state_d = chr_pkg::ST_MIX_WAIT;
      chr_pkg::ST_MIX_WAIT: begin
        if (mix_done) begin
          if (op_q == chr_pkg::OP_LOOKUP || k_q == LastK) begin
            state_d = chr_pkg::ST_SCAN;
          end else begin
            state_d = chr_pkg::ST_MIX_GO;
          end
        end
      end
      chr_pkg::ST_FIND: begin
        if (scan_done) begin
          if (op_q == chr_pkg::OP_INSERT && !hit_q && free_found_q) begin
            state_d = chr_pkg::ST_MIX_GO;
          end else begin
            state_d = chr_pkg::ST_RESULT;
          end
        end
      end
      chr_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (op_q == chr_pkg::OP_INSERT && !collide_q) begin
            state_d = chr_pkg::ST_WRITE;
          end else begin
            state_d = chr_pkg::ST_RESULT;
          end
        end
      end
      chr_pkg::ST_WRITE: begin
        if (k_q == LastK) begin
          state_d = chr_pkg::ST_RESULT;
        end
      end
      chr_pkg::ST_RESULT: begin
        if (out_load) begin
          state_d = chr_pkg::ST_IDLE;
        end
      end
      default: state_d = chr_pkg::ST_IDLE;
    endcase
  end

  // datapath and strobes
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    id_d         = id_q;
    seed_d       = seed_q;
    np_d         = np_q;
    m_d          = m_q;
    k_d          = k_q;
    slot_d       = slot_q;
    pa_d         = pa_q;
    scan_on_d    = scan_on_q;
    tag_vld_d    = 1'b0;
    tag_used_d   = tag_used_q;
    tag_slot_d   = tag_slot_q;
    hit_d        = hit_q;
    hit_slot_d   = hit_slot_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    collide_d    = collide_q;
    any_d        = any_q;
    best_low_d   = best_low_q;
    own_low_d    = own_low_q;
    above_d      = above_q;
    best_up_d    = best_up_q;
    own_up_d     = own_up_q;
    mix_start    = (state_q == chr_pkg::ST_MIX_GO);
    mix_value    = (op_q == chr_pkg::OP_LOOKUP) ? key_q : seed_q[k_q];
    wr           = '0;
    wr_slot      = (op_q == chr_pkg::OP_REMOVE) ? hit_slot_q : free_slot_q;
    wr_pt        = PtW'(PtW'(free_slot_q) * PtW'(POINTS_PER_NODE) + PtW'(k_q));

    unique case (state_q)
      chr_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_d  = chr_pkg::chr_op_e'(operation_i);
          key_d = lookup_key_i;
          id_d  = node_ident_i & IdMask;
          for (int j = 0; j < POINTS_PER_NODE; j++) begin
            seed_d[j] = seeds_in[j];
          end
          k_d          = '0;
          slot_d       = '0;
          pa_d         = '0;
          scan_on_d    = 1'b1;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          collide_d    = 1'b0;
          any_d        = 1'b0;
          above_d      = 1'b0;
        end
      end
      chr_pkg::ST_MIX_WAIT: begin
        if (mix_done) begin
          if (op_q == chr_pkg::OP_LOOKUP) begin
            m_d = mix_res;
          end else begin
            np_d[k_q] = mix_res;
            for (int j = 0; j < POINTS_PER_NODE; j++) begin
              if (KW'(j) < k_q && np_q[j] == mix_res) begin
                collide_d = 1'b1;
              end
            end
            if (k_q != LastK) begin
              k_d = k_q + KW'(1);
            end
          end
          if (op_q == chr_pkg::OP_LOOKUP || k_q == LastK) begin
            k_d       = '0;
            slot_d    = '0;
            pa_d      = '0;
            scan_on_d = 1'b1;
          end
        end
      end
      chr_pkg::ST_FIND: begin
        if (scan_on_q) begin
          tag_vld_d  = 1'b1;
          tag_used_d = used[slot_q];
          tag_slot_d = slot_q;
          if (slot_q == LastSlot) begin
            scan_on_d = 1'b0;
          end else begin
            slot_d = slot_q + SlotW'(1);
          end
        end
        if (tag_vld_q) begin
          if (tag_used_q && rd_node == id_q) begin
            hit_d      = 1'b1;
            hit_slot_d = tag_slot_q;
          end
          if (!tag_used_q && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = tag_slot_q;
          end
        end
        if (scan_done && op_q == chr_pkg::OP_REMOVE && hit_q) begin
          wr.clr_used = 1'b1;
        end
      end
      chr_pkg::ST_SCAN: begin
        if (scan_on_q) begin
          tag_vld_d  = 1'b1;
          tag_used_d = used[slot_q];
          tag_slot_d = slot_q;
          if (pa_q == LastPt) begin
            scan_on_d = 1'b0;
          end else begin
            pa_d = pa_q + PtW'(1);
          end
          if (k_q == LastK) begin
            k_d = '0;
            if (slot_q != LastSlot) begin
              slot_d = slot_q + SlotW'(1);
            end
          end else begin
            k_d = k_q + KW'(1);
          end
        end
        if (tag_vld_q && tag_used_q) begin
          if (op_q == chr_pkg::OP_LOOKUP) begin
            any_d = 1'b1;
            if (!any_q || rd_point < best_low_q) begin
              best_low_d = rd_point;
              own_low_d  = rd_node;
            end
            if (rd_point >= m_q && (!above_q || rd_point < best_up_q)) begin
              above_d   = 1'b1;
              best_up_d = rd_point;
              own_up_d  = rd_node;
            end
          end else begin
            for (int j = 0; j < POINTS_PER_NODE; j++) begin
              if (rd_point == np_q[j]) begin
                collide_d = 1'b1;
              end
            end
          end
        end
      end
      chr_pkg::ST_WRITE: begin
        wr.point_we = 1'b1;
        if (k_q == '0) begin
          wr.node_we  = 1'b1;
          wr.set_used = 1'b1;
        end
        if (k_q != LastK) begin
          k_d = k_q + KW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result fields
  always_comb begin
    res_status = chr_pkg::STAT_OK;
    res_owner  = '0;
    res_mixed  = '0;
    unique case (op_q)
      chr_pkg::OP_LOOKUP: begin
        if (!any_q) begin
          res_status = chr_pkg::STAT_EMPTY;
        end else begin
          res_owner = above_q ? own_up_q : own_low_q;
          res_mixed = m_q;
        end
      end
      chr_pkg::OP_INSERT: begin
        priority if (hit_q) begin
          res_status = chr_pkg::STAT_PRESENT;
        end else if (!free_found_q) begin
          res_status = chr_pkg::STAT_FULL;
        end else if (collide_q) begin
          res_status = chr_pkg::STAT_COLLIDE;
        end else begin
          res_status = chr_pkg::STAT_OK;
        end
      end
      chr_pkg::OP_REMOVE: begin
        if (!hit_q) begin
          res_status = chr_pkg::STAT_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chr_pkg::ST_IDLE;
      scan_on_q   <= 1'b0;
      tag_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_on_q   <= scan_on_d;
      tag_vld_q   <= tag_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    id_q         <= id_d;
    seed_q       <= seed_d;
    np_q         <= np_d;
    m_q          <= m_d;
    k_q          <= k_d;
    slot_q       <= slot_d;
    pa_q         <= pa_d;
    tag_used_q   <= tag_used_d;
    tag_slot_q   <= tag_slot_d;
    hit_q        <= hit_d;
    hit_slot_q   <= hit_slot_d;
    free_found_q <= free_found_d;
    free_slot_q  <= free_slot_d;
    collide_q    <= collide_d;
    any_q        <= any_d;
    best_low_q   <= best_low_d;
    own_low_q    <= own_low_d;
    above_q      <= above_d;
    best_up_q    <= best_up_d;
    own_up_q     <= own_up_d;
    if (out_load) begin
      status_out_q <= res_status;
      owner_out_q  <= res_owner;
      mixed_out_q  <= res_mixed;
    end
  end

  assign in_stall_o    = (state_q != chr_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_out_q;
  assign owner_node_o  = owner_out_q;
  assign mixed_point_o = mixed_out_q;

`ifndef NO_ASSERTIONS
  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == chr_pkg::ST_RESULT)
    else $error("result beat raised outside result state");

  a_mix_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_done |-> state_q == chr_pkg::ST_MIX_WAIT)
    else $error("mix finished while sequencer not waiting");

  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == chr_pkg::ST_WRITE |-> free_found_q && !hit_q && !collide_q)
    else $error("point write without a clean free slot");

  a_tag_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_vld_q |-> (state_q == chr_pkg::ST_FIND || state_q == chr_pkg::ST_SCAN))
    else $error("read tag outside a scan");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == chr_pkg::STAT_EMPTY |->
      owner_node_o == 16'd0 && mixed_point_o == 64'd0)
    else $error("empty ring result carries data");
`endif

endmodule
`default_nettype wire

// File: dv/tb_consistent_hash_ring.sv
// ----------------------------------------------------------------------------
// tb_consistent_hash_ring
// Self-checking bench for the splitmix64 consistent-hash ring.
// Drives lookup, insert, remove and the spare opcode through the valid/stall
// input channel, predicts every result with an independent model of the ring,
// and checks each output beat in order. Both channels idle at random, and the
// output is held off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_consistent_hash_ring;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RingPoints = chr_pkg::MaxNodes * chr_pkg::PointsPerNode;
  localparam int unsigned IdentPool  = 20;
  localparam int unsigned RandBeats  = 200;

  typedef struct {
    chr_pkg::chr_op_e op;
    logic [63:0]      key;
    logic [15:0]      ident;
    logic [63:0]      seed_a;
    logic [63:0]      seed_b;
    logic [63:0]      seed_c;
  } ring_item_t;

  typedef struct {
    chr_pkg::chr_status_e status;
    logic [15:0]          owner;
    logic [63:0]          mixed;
  } ring_result_t;

  class ring_scoreboard;
    bit           slot_busy [chr_pkg::MaxNodes];
    logic [15:0]  slot_ident[chr_pkg::MaxNodes];
    logic [63:0]  ring_pos  [RingPoints];
    ring_result_t expected[$];
    int           mismatches;
    int           op_seen  [4];
    int           stat_seen[8];

    function logic [63:0] splitmix(logic [63:0] v);
      v = (v ^ (v >> 30)) * chr_pkg::MixMulA;
      v = (v ^ (v >> 27)) * chr_pkg::MixMulB;
      return v ^ (v >> 31);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function int slot_of(logic [15:0] id);
      for (int s = 0; s < chr_pkg::MaxNodes; s++)
        if (slot_busy[s] && slot_ident[s] == id) return s;
      return -1;
    endfunction

    function bit pos_taken(logic [63:0] p);
      for (int s = 0; s < chr_pkg::MaxNodes; s++)
        if (slot_busy[s])
          for (int k = 0; k < chr_pkg::PointsPerNode; k++)
            if (ring_pos[s * chr_pkg::PointsPerNode + k] == p) return 1'b1;
      return 1'b0;
    endfunction

    function void note_input(ring_item_t it);
      ring_result_t r;
      logic [15:0]  id;
      logic [63:0]  m, p, best_up, best_low;
      logic [63:0]  np[3];
      logic [63:0]  seeds[3];
      logic [15:0]  own_up, own_low;
      bit           any, above;
      int           free_slot;
      int           s;

      id = it.ident & 16'((64'd1 << chr_pkg::NodeBits) - 1);
      r.status = chr_pkg::STAT_OK;
      r.owner  = '0;
      r.mixed  = '0;
      op_seen[it.op]++;
      case (it.op)
        chr_pkg::OP_LOOKUP: begin
          any = 1'b0; above = 1'b0;
          best_up = '0; best_low = '0; own_up = '0; own_low = '0;
          m = splitmix(it.key);
          for (int t = 0; t < chr_pkg::MaxNodes; t++) begin
            if (!slot_busy[t]) continue;
            for (int k = 0; k < chr_pkg::PointsPerNode; k++) begin
              p = ring_pos[t * chr_pkg::PointsPerNode + k];
              if (!any || p < best_low) begin
                best_low = p;
                own_low  = slot_ident[t];
              end
              any = 1'b1;
              if (p >= m && (!above || p < best_up)) begin
                best_up = p;
                own_up  = slot_ident[t];
                above   = 1'b1;
              end
            end
          end
          if (!any) begin
            r.status = chr_pkg::STAT_EMPTY;
          end else begin
            r.mixed = m;
            r.owner = above ? own_up : own_low;
          end
        end
        chr_pkg::OP_INSERT: begin
          free_slot = -1;
          seeds[0] = it.seed_a; seeds[1] = it.seed_b; seeds[2] = it.seed_c;
          if (slot_of(id) >= 0) begin
            r.status = chr_pkg::STAT_PRESENT;
          end else begin
            for (int t = chr_pkg::MaxNodes - 1; t >= 0; t--)
              if (!slot_busy[t]) free_slot = t;
            if (free_slot < 0) begin
              r.status = chr_pkg::STAT_FULL;
            end else begin
              for (int k = 0; k < chr_pkg::PointsPerNode; k++) begin
                np[k] = splitmix(seeds[k]);
                if (pos_taken(np[k])) r.status = chr_pkg::STAT_COLLIDE;
                for (int j = 0; j < k; j++)
                  if (np[j] == np[k]) r.status = chr_pkg::STAT_COLLIDE;
              end
              if (r.status == chr_pkg::STAT_OK) begin
                slot_busy[free_slot]  = 1'b1;
                slot_ident[free_slot] = id;
                for (int k = 0; k < chr_pkg::PointsPerNode; k++)
                  ring_pos[free_slot * chr_pkg::PointsPerNode + k] = np[k];
              end
            end
          end
        end
        chr_pkg::OP_REMOVE: begin
          s = slot_of(id);
          if (s < 0) r.status = chr_pkg::STAT_ABSENT;
          else slot_busy[s] = 1'b0;
        end
        default: ;
      endcase
      expected.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [15:0] own, logic [63:0] mp);
      ring_result_t want;
      if (!$isunknown(st)) stat_seen[st]++;
      if (expected.size() == 0) begin
        report($sformatf("unexpected beat status=%0d owner=%h point=%h", st, own, mp));
        return;
      end
      want = expected.pop_front();
      if (st !== want.status)
        report($sformatf("status exp %0d got %0d", want.status, st));
      if (own !== want.owner)
        report($sformatf("owner_node exp %h got %h", want.owner, own));
      if (mp !== want.mixed)
        report($sformatf("mixed_point exp %h got %h", want.mixed, mp));
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i   = '0;
  logic [63:0] lookup_key_i  = '0;
  logic [15:0] node_ident_i  = '0;
  logic [63:0] seed_first_i  = '0;
  logic [63:0] seed_second_i = '0;
  logic [63:0] seed_third_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] owner_node_o;
  logic [63:0] mixed_point_o;

  ring_scoreboard sb;
  int             tx_idle_pct;
  int             rx_idle_pct;
  int             hold_left;
  logic [15:0]    id_pool[IdentPool];
  logic [63:0]    seed_pool[$];

  consistent_hash_ring uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .lookup_key_i (lookup_key_i),
    .node_ident_i (node_ident_i),
    .seed_first_i (seed_first_i),
    .seed_second_i(seed_second_i),
    .seed_third_i (seed_third_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .owner_node_o (owner_node_o),
    .mixed_point_o(mixed_point_o)
  );

  always #2 clk_i = ~clk_i;

  // output side: random stall, or a forced hold while hold_left runs down
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, owner_node_o, mixed_point_o);
  end

  function automatic ring_item_t beat_of(chr_pkg::chr_op_e op, logic [63:0] key,
                                         logic [15:0] id, logic [63:0] sa,
                                         logic [63:0] sb_, logic [63:0] sc);
    ring_item_t it;
    it.op = op; it.key = key; it.ident = id;
    it.seed_a = sa; it.seed_b = sb_; it.seed_c = sc;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pooled_seed();
    return seed_pool[$urandom_range(seed_pool.size() - 1)];
  endfunction

  // insert-heavy and remove-heavy stretches alternate so the ring swings
  // between empty and full
  function automatic ring_item_t random_beat(int n);
    ring_item_t it;
    int         roll, sub, ins_w, rem_w;
    ins_w = ((n / 40) % 2 == 0) ? 55 : 15;
    rem_w = ((n / 40) % 2 == 0) ? 10 : 45;
    it = beat_of(chr_pkg::OP_LOOKUP, rand64(), 16'($urandom), rand64(), rand64(), rand64());
    if ($urandom_range(99) < 85) it.ident = id_pool[$urandom_range(IdentPool - 1)];
    roll = $urandom_range(99);
    sub  = $urandom_range(99);
    if (roll < ins_w) begin
      it.op = chr_pkg::OP_INSERT;
      if (seed_pool.size() != 0 && sub < 4) it.seed_a = pooled_seed();
      else if (seed_pool.size() != 0 && sub < 8) it.seed_b = pooled_seed();
      else if (seed_pool.size() != 0 && sub < 12) it.seed_c = pooled_seed();
      else if (sub < 15) it.seed_c = it.seed_a;
      else if (sub < 17) it.seed_b = it.seed_a;
    end else if (roll < ins_w + rem_w) begin
      it.op = chr_pkg::OP_REMOVE;
    end else if (roll < 95) begin
      if (seed_pool.size() != 0 && sub < 20) it.key = pooled_seed();
      else if (sub < 23) it.key = '0;
      else if (sub < 26) it.key = '1;
    end else begin
      it.op = chr_pkg::OP_NONE;
    end
    return it;
  endfunction

  task automatic push_beat(input ring_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= it.op;
    lookup_key_i  <= it.key;
    node_ident_i  <= it.ident;
    seed_first_i  <= it.seed_a;
    seed_second_i <= it.seed_b;
    seed_third_i  <= it.seed_c;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    if (it.op == chr_pkg::OP_INSERT) begin
      seed_pool.push_back(it.seed_a);
      seed_pool.push_back(it.seed_b);
      seed_pool.push_back(it.seed_c);
      while (seed_pool.size() > 48) void'(seed_pool.pop_front());
    end
  endtask

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [63:0] s0;
    sb        = new();
    hold_left = 0;
    tx_idle_pct = 26;
    rx_idle_pct = 61;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hffff;
    for (int i = 2; i < IdentPool; i++) id_pool[i] = 16'($urandom);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty ring, absent node, spare opcode, field extremes,
    // duplicate node, collisions inside one insert and against the ring,
    // exact point hit, wrap past the largest point
    s0 = rand64();
    push_beat(beat_of(chr_pkg::OP_LOOKUP, '0, '0, '0, '0, '0));
    push_beat(beat_of(chr_pkg::OP_REMOVE, '1, 16'hffff, '1, '1, '1));
    push_beat(beat_of(chr_pkg::OP_NONE, '1, 16'hffff, '1, '1, '1));
    push_beat(beat_of(chr_pkg::OP_INSERT, '0, 16'h0000, '0, '1, 64'h5555_5555_5555_5555));
    push_beat(beat_of(chr_pkg::OP_INSERT, '0, 16'h0000, s0, rand64(), rand64()));
    push_beat(beat_of(chr_pkg::OP_INSERT, '0, 16'h0001, s0, s0, rand64()));
    push_beat(beat_of(chr_pkg::OP_INSERT, '0, 16'h0002, rand64(), rand64(), s0));
    push_beat(beat_of(chr_pkg::OP_INSERT, '0, 16'h0003, rand64(), '1, rand64()));
    push_beat(beat_of(chr_pkg::OP_LOOKUP, '0, '1, '1, '1, '1));
    push_beat(beat_of(chr_pkg::OP_LOOKUP, '1, '0, '0, '0, '0));
    push_beat(beat_of(chr_pkg::OP_LOOKUP, 64'h5555_5555_5555_5555, '0, '0, '0, '0));
    push_beat(beat_of(chr_pkg::OP_INSERT, '0, 16'hffff, s0, rand64(), rand64()));
    push_beat(beat_of(chr_pkg::OP_INSERT, '0, 16'hffff, rand64(), rand64(), rand64()));
    push_beat(beat_of(chr_pkg::OP_LOOKUP, rand64(), '0, '0, '0, '0));
    push_beat(beat_of(chr_pkg::OP_LOOKUP, s0, '0, '0, '0, '0));
    push_beat(beat_of(chr_pkg::OP_REMOVE, '0, 16'h0000, '0, '0, '0));
    push_beat(beat_of(chr_pkg::OP_REMOVE, '0, 16'h0000, '0, '0, '0));
    push_beat(beat_of(chr_pkg::OP_REMOVE, '0, 16'hffff, '0, '0, '0));
    push_beat(beat_of(chr_pkg::OP_LOOKUP, rand64(), '0, '0, '0, '0));

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 61 : 0;
      rx_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 26 : 0;
      for (int n = 0; n < RandBeats; n++) begin
        push_beat(random_beat(n));
        if (phase == 2 && n == 0) hold_left = 300;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    if (sb.expected.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected.size()));
    $display("Covered %0d lookups, %0d inserts, %0d removes, %0d spare-opcode beats",
             sb.op_seen[chr_pkg::OP_LOOKUP], sb.op_seen[chr_pkg::OP_INSERT],
             sb.op_seen[chr_pkg::OP_REMOVE], sb.op_seen[chr_pkg::OP_NONE]);
    $display("Status mix: ok %0d, empty %0d, present %0d, absent %0d, collide %0d, full %0d",
             sb.stat_seen[chr_pkg::STAT_OK], sb.stat_seen[chr_pkg::STAT_EMPTY],
             sb.stat_seen[chr_pkg::STAT_PRESENT], sb.stat_seen[chr_pkg::STAT_ABSENT],
             sb.stat_seen[chr_pkg::STAT_COLLIDE], sb.stat_seen[chr_pkg::STAT_FULL]);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in total", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/chr_pkg.sv
rtl/core/chr_mix.sv
rtl/core/chr_store.sv
rtl/core/consistent_hash_ring.sv
dv/tb_consistent_hash_ring.sv
